FILE: design/indexed_list_insert_delete_defines.svh
// Assertion macros used by the list datapath.
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`ifndef SYNTH
// Checked on every clock edge outside reset.
`define ILID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ILID_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ILID_ASSERT(label, prop, msg)
`define ILID_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

FILE: design/ilid_pkg.sv
package ilid_pkg;

    // List capacity and derived widths.
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths.
    localparam int FUNC_W   = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Width used to compare positions against the count.
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FIND   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic read;
        logic step;
        logic put;
        logic commit;
        logic capture;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic err;
        logic op_delete;
        logic op_find;
        logic more;
        logic out_busy;
    } stat_t;

endpackage

FILE: design/ilid_ram.sv
module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/ilid_ctrl.sv
module ilid_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  ilid_pkg::stat_t st,
    output ilid_pkg::cmd_t  cmd
);

    import ilid_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CHECK    = 3'd1;
    localparam logic [2:0] S_MOVE     = 3'd2;
    localparam logic [2:0] S_PUT      = 3'd3;
    localparam logic [2:0] S_FIND_CAP = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // A new request is taken only between operations.
    assign in_stall = (state_reg != S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.err)
                begin
                    state_next = S_FINISH;
                end
                else if (st.op_find)
                begin
                    cmd.read   = 1'b1;
                    state_next = S_FIND_CAP;
                end
                else
                begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE:
            begin
                if (st.more)
                begin
                    cmd.step = 1'b1;
                end
                else if (st.op_delete)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_FINISH;
            end
            S_FIND_CAP:
            begin
                cmd.capture = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: design/ilid_dp.sv
`include "indexed_list_insert_delete_defines.svh"

module ilid_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ilid_pkg::cmd_t                      cmd,
    output ilid_pkg::stat_t                     st,
    input  logic [ilid_pkg::FUNC_W-1:0]         func,
    input  logic [ilid_pkg::POS_W-1:0]          position,
    input  logic signed [ilid_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ilid_pkg::STATUS_W-1:0]       status,
    output logic signed [ilid_pkg::DATA_W-1:0]  read_value,
    output logic [ilid_pkg::COUNT_W-1:0]        count
);

    import ilid_pkg::*;

    // Request registers.
    logic [FUNC_W-1:0]   func_reg;
    logic [CMP_W-1:0]    pos_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [CMP_W-1:0]    ptr_reg;
    logic [CMP_W-1:0]    ptr_next;
    logic [DATA_W-1:0]   find_reg;

    // List state.
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    used_next;

    // Pending move write.
    logic                wr_pend_reg;
    logic [IDX_W-1:0]    wr_addr_reg;

    // Result registers.
    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [DATA_W-1:0]   out_rd_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    // Memory ports.
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic [CMP_W-1:0]    pos_in_ext;
    logic [CMP_W-1:0]    used_ext;
    logic                is_insert;

    assign pos_in_ext = CMP_W'(position);
    assign used_ext   = CMP_W'(used_reg);
    assign is_insert  = (func_reg == FN_INSERT);

    // Range and capacity checks on the incoming request.
    always_comb
    begin
        status_next = ST_OK;
        case (func)
            FN_INSERT:
            begin
                if (pos_in_ext > used_ext)
                begin
                    status_next = ST_INDEX;
                end
                else if (used_reg == CNT_W'(DEPTH))
                begin
                    status_next = ST_FULL;
                end
            end
            FN_DELETE, FN_FIND:
            begin
                if (pos_in_ext >= used_ext)
                begin
                    status_next = ST_INDEX;
                end
            end
            default:
            begin
                status_next = ST_INDEX;
            end
        endcase
    end

    // Status toward the controller.
    always_comb
    begin
        st.err       = (status_reg != ST_OK);
        st.op_delete = (func_reg == FN_DELETE);
        st.op_find   = (func_reg == FN_FIND);
        st.more      = is_insert ? (ptr_reg > pos_reg)
                                 : ((ptr_reg + CMP_W'(1)) < used_ext);
        st.out_busy  = out_valid_reg && out_stall;
    end

    // Move pointer: walks down for an insert and up for a delete.
    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = (func == FN_INSERT) ? used_ext : pos_in_ext;
        end
        else if (cmd.step)
        begin
            ptr_next = is_insert ? (ptr_reg - CMP_W'(1)) : (ptr_reg + CMP_W'(1));
        end
    end

    // Memory read and write selection.
    always_comb
    begin
        ram_re    = cmd.read || cmd.step;
        ram_raddr = pos_reg[IDX_W-1:0];
        if (cmd.step)
        begin
            ram_raddr = is_insert ? ptr_next[IDX_W-1:0] : ptr_next[IDX_W-1:0];
        end
        ram_we    = wr_pend_reg || cmd.put;
        ram_waddr = wr_pend_reg ? wr_addr_reg : pos_reg[IDX_W-1:0];
        ram_wdata = wr_pend_reg ? ram_rdata : val_reg;
    end

    // Count update.
    always_comb
    begin
        used_next = used_reg;
        if (cmd.put)
        begin
            used_next = used_reg + CNT_W'(1);
        end
        else if (cmd.commit)
        begin
            used_next = used_reg - CNT_W'(1);
        end
    end

    ilid_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            wr_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg    <= used_next;
            wr_pend_reg <= cmd.step;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.step)
        begin
            wr_addr_reg <= ptr_reg[IDX_W-1:0];
        end
        if (cmd.load)
        begin
            func_reg   <= func;
            pos_reg    <= pos_in_ext;
            val_reg    <= DATA_W'(value);
            status_reg <= status_next;
            find_reg   <= '0;
        end
        else if (cmd.capture)
        begin
            find_reg <= ram_rdata;
        end
        if (cmd.finish)
        begin
            out_status_reg <= status_reg;
            out_rd_reg     <= find_reg;
            out_count_reg  <= used_ext[COUNT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign read_value = DATA_W'(out_rd_reg);
    assign count      = out_count_reg;

    `ILID_ASSERT(a_used_bound, used_reg <= CNT_W'(DEPTH), "count exceeds capacity")
    `ILID_ASSERT(a_one_write, !(wr_pend_reg && cmd.put), "move write collides with value write")
    `ILID_ASSERT(a_used_step, (used_reg != $past(used_reg)) |-> ((used_reg == $past(used_reg) + CNT_W'(1)) || (used_reg + CNT_W'(1) == $past(used_reg))), "count moved by more than one")
    `ILID_ASSERT(a_rd_zero, (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_rd_reg == '0), "failed request returns a value")

endmodule

FILE: design/indexed_list_insert_delete.sv
// A rejected request goes straight from the check to the finish, a find reads and captures
// one entry, and an insert at position 0 of a list one short of full shifts the most entries.
// One entry moves per cycle through the list memory during an insert or delete. The block
// takes a new request in the cycle after the result is loaded; a result still held by
// out_stall delays the next one's finish.
// Reset clears the count and the handshake state; list memory is not cleared.
module indexed_list_insert_delete (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ilid_pkg::FUNC_W-1:0]         func,
    input  logic [ilid_pkg::POS_W-1:0]          position,
    input  logic signed [ilid_pkg::DATA_W-1:0]  value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ilid_pkg::STATUS_W-1:0]       status,
    output logic signed [ilid_pkg::DATA_W-1:0]  read_value,
    output logic [ilid_pkg::COUNT_W-1:0]        count
);

    import ilid_pkg::*;

    cmd_t  cmd;
    stat_t st;

    // Sequencer for each request.
    ilid_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    // List storage, count and result registers.
    ilid_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .func       (func),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

endmodule

FILE: tb/sv/indexed_list_insert_delete_tb.sv
module indexed_list_insert_delete_tb;
    import ilid_pkg::*;

    // The operation code that the block does not define.
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam int MAX_WAIT        = 18;
    localparam int HOLD_CYCLES     = 80;
    localparam int IDLE_LIMIT      = 3000;
    localparam int RANDOM_REQUESTS = 1725;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct {
        logic [FUNC_W-1:0]        op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] data;
        int                       gap;
        bit                       drain;
        bit                       hold;
    } list_request_t;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] read_value;
        logic [COUNT_W-1:0]       count;
    } list_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [FUNC_W-1:0]          func = '0;
    logic [POS_W-1:0]           position = '0;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   read_value;
    logic [COUNT_W-1:0]         count;

    // Requests waiting to be offered and results waiting to arrive.
    list_request_t request_queue[$];
    list_result_t  pending_list_results[$];

    // Predicted list contents.
    logic signed [DATA_W-1:0] list_words [DEPTH];
    int list_len = 0;

    // Length tracked while the request sequence is built.
    int  plan_len = 0;
    bit  tx_quiet = 1'b0;
    int  quiet_left = 0;

    // Handshake flags seen at the last rising edge.
    logic req_taken = 1'b0;
    logic res_taken = 1'b0;

    list_request_t cur_req;
    bit  have_cur = 1'b0;
    int  gap_left = 0;
    int  hold_asked = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;
    bit  rx_quiet = 1'b0;

    int  mismatches = 0;
    int  results_checked = 0;
    int  ops_seen [4] = '{0, 0, 0, 0};
    int  rejected = 0;
    int  refused_full = 0;
    int  holds_done = 0;

    indexed_list_insert_delete DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .read_value (read_value),
        .count      (count)
    );

    always #6 clk = ~clk;

    // Apply one request to the predicted list and queue the result it gives.
    function automatic void predict_list_op(input logic [FUNC_W-1:0] op,
                                            input logic [POS_W-1:0] pos,
                                            input logic signed [DATA_W-1:0] data);
        list_result_t res;
        res.status = ST_OK;
        res.read_value = '0;
        ops_seen[op]++;
        case (op)
            FN_INSERT:
            begin
                if (pos > list_len)
                begin
                    res.status = ST_INDEX;
                end
                else if (list_len >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    for (int i = list_len; i > pos; i--)
                    begin
                        list_words[i] = list_words[i - 1];
                    end
                    list_words[pos] = data;
                    list_len++;
                end
            end
            FN_DELETE:
            begin
                if (pos >= list_len)
                begin
                    res.status = ST_INDEX;
                end
                else
                begin
                    for (int i = pos; i + 1 < list_len; i++)
                    begin
                        list_words[i] = list_words[i + 1];
                    end
                    list_len--;
                end
            end
            FN_FIND:
            begin
                if (pos >= list_len)
                begin
                    res.status = ST_INDEX;
                end
                else
                begin
                    res.read_value = list_words[pos];
                end
            end
            default:
            begin
                res.status = ST_INDEX;
            end
        endcase
        if (res.status == ST_INDEX)
        begin
            rejected++;
        end
        if (res.status == ST_FULL)
        begin
            refused_full++;
        end
        res.count = COUNT_W'(list_len);
        pending_list_results.push_back(res);
    endfunction

    // Add a request to the sequence, drawing the sender's wait in front of it.
    function automatic void queue_request(input logic [FUNC_W-1:0] op,
                                          input logic [POS_W-1:0] pos,
                                          input logic signed [DATA_W-1:0] data,
                                          input bit drain,
                                          input bit hold);
        list_request_t req;
        req.op = op;
        req.pos = pos;
        req.data = data;
        req.drain = drain;
        req.hold = hold;
        req.gap = (tx_quiet || quiet_left > 0) ? 0 : $urandom_range(0, MAX_WAIT);
        if (quiet_left > 0)
        begin
            quiet_left--;
        end
        if (op == FN_INSERT && pos <= plan_len && plan_len < DEPTH)
        begin
            plan_len++;
        end
        else if (op == FN_DELETE && pos < plan_len)
        begin
            plan_len--;
        end
        request_queue.push_back(req);
    endfunction

    // Sample both handshakes, check results and watch for a hang.
    always @(posedge clk)
    begin : watch_handshakes
        list_result_t want;
        int idle_cycles;
        req_taken <= in_valid && !in_stall;
        res_taken <= out_valid && !out_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            predict_list_op(func, position, value);
        end
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_list_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: status %0d read_value %0d count %0d",
                             status, read_value, count);
                end
            end
            else
            begin
                want = pending_list_results.pop_front();
                results_checked++;
                if (status !== want.status || read_value !== want.read_value
                    || count !== want.count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected status %0d read_value %0d count %0d, got status %0d read_value %0d count %0d",
                                 results_checked, want.status, want.read_value, want.count,
                                 status, read_value, count);
                    end
                end
            end
        end
        // Any accepted request or result shows the block is still moving.
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: nothing moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Offer requests from the queue, holding each one until it is taken.
    always @(negedge clk)
    begin : drive_requests
        logic nxt_valid;
        nxt_valid = in_valid && !req_taken;
        if (rst_n && !nxt_valid)
        begin
            if (!have_cur && request_queue.size() > 0)
            begin
                cur_req = request_queue.pop_front();
                gap_left = cur_req.gap;
                have_cur = 1'b1;
            end
            if (have_cur)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (!cur_req.drain || pending_list_results.size() == 0)
                begin
                    nxt_valid = 1'b1;
                    have_cur = 1'b0;
                    func <= cur_req.op;
                    position <= cur_req.pos;
                    value <= cur_req.data;
                    if (cur_req.hold)
                    begin
                        hold_asked <= hold_asked + 1;
                    end
                end
            end
        end
        in_valid <= nxt_valid;
    end

    // Stall the result side for a random wait per result, or a long hold-off.
    always @(negedge clk)
    begin : drive_stall
        if (rst_n)
        begin
            if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (res_taken)
            begin
                if ($urandom_range(0, 31) == 0)
                begin
                    rx_quiet = !rx_quiet;
                end
                stall_left = rx_quiet ? 0 : $urandom_range(0, MAX_WAIT);
            end
            out_stall <= (hold_left > 0) || (stall_left > 0);
            if (hold_left > 0)
            begin
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
        end
    end

    // Build the request sequence, run it and report.
    initial
    begin : run_test
        logic [FUNC_W-1:0]        op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] data;
        bit  grow;
        int  roll;

        // Errors on an empty list, the unused code included.
        queue_request(FN_FIND, 5'd0, 32'sd0, 1'b0, 1'b0);
        queue_request(FN_DELETE, 5'd0, 32'sd0, 1'b0, 1'b0);
        queue_request(FN_INSERT, 5'd1, 32'sd5, 1'b0, 1'b0);
        queue_request(FN_UNUSED, 5'd0, 32'sd0, 1'b0, 1'b0);

        // Extreme values at the front and at the end of the list.
        queue_request(FN_INSERT, 5'd0, 32'sh8000_0000, 1'b0, 1'b0);
        queue_request(FN_INSERT, 5'd1, 32'sh7fff_ffff, 1'b0, 1'b0);
        queue_request(FN_INSERT, 5'd0, -32'sd1, 1'b0, 1'b0);
        queue_request(FN_INSERT, 5'd3, 32'sd0, 1'b0, 1'b0);
        queue_request(FN_FIND, 5'd0, 32'sd0, 1'b0, 1'b0);
        queue_request(FN_FIND, 5'd3, 32'sd0, 1'b0, 1'b0);

        // Positions far out of range.
        queue_request(FN_INSERT, 5'd31, 32'sd7, 1'b0, 1'b0);
        queue_request(FN_FIND, 5'd31, 32'sd0, 1'b0, 1'b0);

        // Fill the list, then an insert at a valid position must be refused as full,
        // while one past the end is still an index error.
        while (plan_len < DEPTH)
        begin
            queue_request(FN_INSERT, POS_W'($urandom_range(0, plan_len)), $urandom,
                          1'b0, 1'b0);
        end
        queue_request(FN_INSERT, 5'd16, 32'sd9, 1'b0, 1'b0);
        queue_request(FN_INSERT, 5'd17, 32'sd9, 1'b0, 1'b0);

        // Random part: mostly valid positions, with the list drifting between
        // empty and full, and a share of arbitrary codes and positions.
        grow = 1'b0;
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ($urandom_range(0, 63) == 0)
            begin
                tx_quiet = !tx_quiet;
            end
            if (plan_len == DEPTH)
            begin
                grow = 1'b0;
            end
            else if (plan_len == 0)
            begin
                grow = 1'b1;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                grow = !grow;
            end
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                op = FUNC_W'($urandom_range(0, 3));
                pos = POS_W'($urandom_range(0, 31));
            end
            else
            begin
                if (roll < 35)
                begin
                    op = FN_FIND;
                end
                else if ($urandom_range(0, 99) < 70)
                begin
                    op = grow ? FN_INSERT : FN_DELETE;
                end
                else
                begin
                    op = grow ? FN_DELETE : FN_INSERT;
                end
                if (op == FN_INSERT)
                begin
                    pos = POS_W'($urandom_range(0, plan_len));
                end
                else
                begin
                    pos = (plan_len == 0) ? 5'd0 : POS_W'($urandom_range(0, plan_len - 1));
                end
            end
            case ($urandom_range(0, 9))
                0: data = 32'sh8000_0000;
                1: data = 32'sh7fff_ffff;
                2: data = 32'sd0;
                3: data = -32'sd1;
                default: data = $urandom;
            endcase
            // Long receiver hold-offs with the sender pushing back to back.
            if (n == 300 || n == 1200)
            begin
                quiet_left = 12;
            end
            queue_request(op, pos, data, n == 0 || n == 700 || n == 1500,
                          n == 300 || n == 1200);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() > 0 || have_cur || in_valid
               || pending_list_results.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("%0d requests: %0d insert, %0d delete, %0d find, %0d unused code",
                 ops_seen[0] + ops_seen[1] + ops_seen[2] + ops_seen[3],
                 ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
        $display("%0d results checked, %0d index errors, %0d refused as full, %0d long hold-offs, %0d mismatches",
                 results_checked, rejected, refused_full, holds_done, mismatches);
        if (mismatches == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
